FILE: sv/pcmr_pkg.sv
`timescale 1ns / 1ps

package pcmr_pkg;

   localparam int MAX_RESULTS  = 16;
   localparam int MAX_CHANNELS = 2;
   localparam int RES_IDX_W    = $clog2(MAX_RESULTS);
   localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);

   localparam int RATE_W       = 18;
   localparam int CHAN_W       = 2;
   localparam int BYTES_W      = 2;
   localparam int SAMPLE_W     = 16;
   localparam int PF_W         = 13;
   localparam int PF_MAX       = 4096;
   localparam int PSIZE_W      = PF_W + 1;
   localparam int IDX_W        = 32;
   localparam int NARROW_SHIFT = 8;

   // frame * in_rate needs the full index width plus the rate width
   localparam int DIV_BITS     = IDX_W + RATE_W;
   localparam int DIV_CNT_W    = $clog2(DIV_BITS + 1);

   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = RATE_W;

   localparam logic [CSR_IDX_W-1:0] REG_IN_RATE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_RATE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IN_CHANNELS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_CHANNELS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_IN_BYTES      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_BYTES     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_PACKET_FRAMES = 3'd6;

   localparam logic [BYTES_W-1:0] BYTES_NARROW = 2'd1;

   typedef struct packed {
      logic                 start;
      logic [DIV_BITS-1:0]  dividend;
      logic [RATE_W-1:0]    divisor;
   } pcmr_div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_BITS-1:0]  quotient;
      logic [RATE_W-1:0]    remainder;
   } pcmr_div_rsp_type;

   typedef struct packed {
      logic                 en;
      logic [RES_IDX_W-1:0] idx;
      logic                 ch;
      logic                 plast;
   } pcmr_wr_type;

   typedef struct packed {
      logic                 go;
      logic [RES_CNT_W-1:0] count;
      logic                 capped;
      logic [SAMPLE_W-1:0]  sample;
   } pcmr_emit_type;

   function automatic logic [CHAN_W-1:0] clamp_chan(input logic [CHAN_W-1:0] v);
      logic [CHAN_W-1:0] r;
      if (v == '0)
         r = CHAN_W'(1);
      else if (v > CHAN_W'(MAX_CHANNELS))
         r = CHAN_W'(MAX_CHANNELS);
      else
         r = v;
      return r;
   endfunction

endpackage

FILE: sv/pcmr_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module pcmr_div import pcmr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  pcmr_div_req_type req,
   output pcmr_div_rsp_type rsp
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_BITS-1:0]  quo_ff;
   logic [RATE_W-1:0]    rem_ff;
   logic [RATE_W-1:0]    dvs_ff;

   logic [RATE_W:0]      trial;
   logic [RATE_W:0]      diff;
   logic                 ge;

   assign trial = {rem_ff, quo_ff[DIV_BITS-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == DIV_CNT_W'(1));
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1))
               busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff <= req.dividend;
         rem_ff <= '0;
         dvs_ff <= req.divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_BITS-2:0], ge};
         rem_ff <= ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

`ifndef NO_ASSERTIONS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff) else $error("divider started while busy");
   a_busy_cnt: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0) else $error("divider busy with zero count");
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (done_ff && dvs_ff != '0) |-> rem_ff < dvs_ff)
      else $error("divider remainder not below divisor");
`endif

endmodule

FILE: sv/pcmr_rbuf.sv
`timescale 1ns / 1ps

// holds the results of one request until the cap flag is known, then drains them
module pcmr_rbuf import pcmr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  pcmr_wr_type         wr,
   input  pcmr_emit_type       emit,
   output logic                emit_done,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic signed [15:0]  rsp_out_sample,
   output logic                rsp_out_channel,
   output logic                rsp_packet_last,
   output logic                rsp_capped,
   output logic                rsp_last
);

   logic                 ch_mem_ff [MAX_RESULTS];
   logic                 pl_mem_ff [MAX_RESULTS];

   logic                 busy_ff;
   logic [RES_CNT_W-1:0] rd_idx_ff;
   logic [RES_CNT_W-1:0] cnt_ff;
   logic                 capped_ff;
   logic [SAMPLE_W-1:0]  sample_ff;

   logic                 rsp_valid_ff;
   logic [SAMPLE_W-1:0]  rsp_sample_ff;
   logic                 rsp_ch_ff;
   logic                 rsp_pl_ff;
   logic                 rsp_capped_ff;
   logic                 rsp_last_ff;

   logic                 load;
   logic                 final_entry;

   assign load        = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign final_entry = RES_CNT_W'(rd_idx_ff + 1'b1) == cnt_ff;
   assign emit_done   = load && final_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit.go) begin
            busy_ff   <= 1'b1;
            rd_idx_ff <= '0;
         end else if (load) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
            if (final_entry)
               busy_ff <= 1'b0;
         end
         rsp_valid_ff <= load || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         ch_mem_ff[wr.idx] <= wr.ch;
         pl_mem_ff[wr.idx] <= wr.plast;
      end
      if (emit.go) begin
         cnt_ff    <= emit.count;
         capped_ff <= emit.capped;
         sample_ff <= emit.sample;
      end
      if (load) begin
         rsp_sample_ff <= sample_ff;
         rsp_ch_ff     <= ch_mem_ff[rd_idx_ff[RES_IDX_W-1:0]];
         rsp_pl_ff     <= pl_mem_ff[rd_idx_ff[RES_IDX_W-1:0]];
         rsp_capped_ff <= capped_ff;
         rsp_last_ff   <= final_entry;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_sample  = rsp_sample_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_packet_last = rsp_pl_ff;
   assign rsp_capped      = rsp_capped_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_go_idle: assert property (@(posedge clock) disable iff (reset)
      emit.go |-> !busy_ff) else $error("drain started while busy");
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      emit_done |=> !busy_ff) else $error("still busy after final entry");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rd_idx_ff < cnt_ff) else $error("read index past count");
`endif

endmodule

FILE: sv/pcm_nearest_resampler_packer.sv
`timescale 1ns / 1ps
// A sample request first steps through its results in S_STEP, then drains them in S_EMIT;
// a request with no results returns straight to idle from S_STEP.
// After reset, a restart or any register write, the next sample request first runs the
// shared 50-bit divider twice to rebuild the source-frame position.
// One request at a time: req_stall holds until the last result is loaded into the output register.
// Reset (synchronous): counters cleared, registers at their defaults, position rebuilt.
module pcm_nearest_resampler_packer import pcmr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic [15:0]           req_sample_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [15:0]    rsp_out_sample,
   output logic                  rsp_out_channel,
   output logic                  rsp_packet_last,
   output logic                  rsp_capped,
   output logic                  rsp_last,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_MUL       = 3'd1;
   localparam logic [2:0] S_DIVA      = 3'd2;
   localparam logic [2:0] S_DIVA_WAIT = 3'd3;
   localparam logic [2:0] S_DIVB      = 3'd4;
   localparam logic [2:0] S_DIVB_WAIT = 3'd5;
   localparam logic [2:0] S_STEP      = 3'd6;
   localparam logic [2:0] S_EMIT      = 3'd7;

   logic [2:0]           state_ff, state_in;
   logic [RATE_W-1:0]    in_rate_ff, in_rate_in;
   logic [RATE_W-1:0]    out_rate_ff, out_rate_in;
   logic [CHAN_W-1:0]    in_chan_ff, in_chan_in;
   logic [CHAN_W-1:0]    out_chan_ff, out_chan_in;
   logic [BYTES_W-1:0]   in_bytes_ff, in_bytes_in;
   logic [BYTES_W-1:0]   out_bytes_ff, out_bytes_in;
   logic [PF_W-1:0]      pf_ff, pf_in;
   logic [IDX_W-1:0]     out_idx_ff, out_idx_in;
   logic [IDX_W-1:0]     in_idx_ff, in_idx_in;
   logic [PF_W-1:0]      pkt_ff, pkt_in;
   logic                 pos_valid_ff, pos_valid_in;
   logic [RES_CNT_W-1:0] n_ff, n_in;

   // source-frame position: q = floor(frame * ir / or), r the remainder
   logic [DIV_BITS-1:0]  q_ff, q_in;
   logic [RATE_W-1:0]    r_ff, r_in;
   logic [RATE_W-1:0]    qs_ff, qs_in;
   logic [RATE_W-1:0]    rs_ff, rs_in;
   logic [DIV_BITS-1:0]  prod_ff, prod_in;
   logic [SAMPLE_W-1:0]  bits_ff, bits_in;

   logic [RATE_W-1:0]    ir, orate;
   logic                 two_in, two_out;
   logic [PF_W-1:0]      pf_sat;
   logic [PSIZE_W-1:0]   psize;
   logic [IDX_W-1:0]     frame;
   logic                 ch, sch;
   logic [DIV_BITS:0]    src;
   logic                 beyond;
   logic                 at_cap;
   logic [PSIZE_W-1:0]   cnt;
   logic                 plast;
   logic [RATE_W:0]      r_sum;
   logic                 r_wrap;
   logic [RATE_W:0]      r_adj;
   logic [SAMPLE_W-1:0]  word;

   pcmr_div_req_type     div_req;
   pcmr_div_rsp_type     div_rsp;
   pcmr_wr_type          wr;
   pcmr_emit_type        emit;
   logic                 emit_done;

   assign ir      = (in_rate_ff == '0) ? RATE_W'(1) : in_rate_ff;
   assign orate   = (out_rate_ff == '0) ? RATE_W'(1) : out_rate_ff;
   assign two_in  = clamp_chan(in_chan_ff) == CHAN_W'(2);
   assign two_out = clamp_chan(out_chan_ff) == CHAN_W'(2);
   assign pf_sat  = (pf_ff == '0) ? PF_W'(1) :
                    (pf_ff > PF_W'(PF_MAX)) ? PF_W'(PF_MAX) : pf_ff;
   assign psize   = two_out ? {pf_sat, 1'b0} : {1'b0, pf_sat};

   assign frame   = two_out ? {1'b0, out_idx_ff[IDX_W-1:1]} : out_idx_ff;
   assign ch      = two_out & out_idx_ff[0];
   assign sch     = two_in & ch;
   assign src     = (two_in ? {q_ff, 1'b0} : {1'b0, q_ff}) + (DIV_BITS + 1)'(sch);
   assign beyond  = src > (DIV_BITS + 1)'(in_idx_ff);
   assign at_cap  = n_ff == RES_CNT_W'(MAX_RESULTS);

   assign cnt     = {1'b0, pkt_ff} + 1'b1;
   assign plast   = cnt >= psize;

   assign r_sum   = {1'b0, r_ff} + {1'b0, rs_ff};
   assign r_wrap  = r_sum >= {1'b0, orate};
   assign r_adj   = r_wrap ? (r_sum - {1'b0, orate}) : r_sum;

   assign word    = (in_bytes_ff == BYTES_NARROW) ?
                    {req_sample_word[7:0], 8'h00} : req_sample_word;

   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      div_req.start    = (state_ff == S_DIVA) || (state_ff == S_DIVB);
      div_req.dividend = (state_ff == S_DIVA) ? prod_ff : DIV_BITS'(ir);
      div_req.divisor  = orate;

      wr.en    = (state_ff == S_STEP) && !beyond && !at_cap;
      wr.idx   = n_ff[RES_IDX_W-1:0];
      wr.ch    = ch;
      wr.plast = plast;

      emit.go     = (state_ff == S_STEP) && (beyond || at_cap) && (n_ff != '0);
      emit.count  = n_ff;
      emit.capped = !beyond;
      emit.sample = bits_ff;
   end

   always_comb begin
      state_in     = state_ff;
      in_rate_in   = in_rate_ff;
      out_rate_in  = out_rate_ff;
      in_chan_in   = in_chan_ff;
      out_chan_in  = out_chan_ff;
      in_bytes_in  = in_bytes_ff;
      out_bytes_in = out_bytes_ff;
      pf_in        = pf_ff;
      out_idx_in   = out_idx_ff;
      in_idx_in    = in_idx_ff;
      pkt_in       = pkt_ff;
      pos_valid_in = pos_valid_ff;
      n_in         = n_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      qs_in        = qs_ff;
      rs_in        = rs_ff;
      prod_in      = prod_ff;
      bits_in      = bits_ff;

      if (csr_write) begin
         pos_valid_in = 1'b0;
         unique case (csr_index)
            REG_IN_RATE:       in_rate_in   = csr_wdata[RATE_W-1:0];
            REG_OUT_RATE:      out_rate_in  = csr_wdata[RATE_W-1:0];
            REG_IN_CHANNELS:   in_chan_in   = csr_wdata[CHAN_W-1:0];
            REG_OUT_CHANNELS:  out_chan_in  = csr_wdata[CHAN_W-1:0];
            REG_IN_BYTES:      in_bytes_in  = csr_wdata[BYTES_W-1:0];
            REG_OUT_BYTES:     out_bytes_in = csr_wdata[BYTES_W-1:0];
            REG_PACKET_FRAMES: pf_in        = csr_wdata[PF_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_action) begin
                  out_idx_in   = '0;
                  in_idx_in    = '0;
                  pkt_in       = '0;
                  pos_valid_in = 1'b0;
               end else begin
                  bits_in  = (out_bytes_ff == BYTES_NARROW) ?
                             {{NARROW_SHIFT{word[15]}}, word[15:NARROW_SHIFT]} : word;
                  n_in     = '0;
                  state_in = (pos_valid_ff && !csr_write) ? S_STEP : S_MUL;
               end
            end
         end
         S_MUL: begin
            prod_in  = DIV_BITS'(frame) * DIV_BITS'(ir);
            state_in = S_DIVA;
         end
         S_DIVA: state_in = S_DIVA_WAIT;
         S_DIVA_WAIT: begin
            if (div_rsp.done) begin
               q_in     = div_rsp.quotient;
               r_in     = div_rsp.remainder;
               state_in = S_DIVB;
            end
         end
         S_DIVB: state_in = S_DIVB_WAIT;
         S_DIVB_WAIT: begin
            if (div_rsp.done) begin
               qs_in        = div_rsp.quotient[RATE_W-1:0];
               rs_in        = div_rsp.remainder;
               pos_valid_in = 1'b1;
               state_in     = S_STEP;
            end
         end
         S_STEP: begin
            if (beyond || at_cap) begin
               in_idx_in = in_idx_ff + 1'b1;
               state_in  = (n_ff != '0) ? S_EMIT : S_IDLE;
            end else begin
               pkt_in     = plast ? '0 : cnt[PF_W-1:0];
               n_in       = n_ff + 1'b1;
               out_idx_in = out_idx_ff + 1'b1;
               // index wrap restarts at frame zero
               if (out_idx_ff == '1) begin
                  q_in = '0;
                  r_in = '0;
               end else if (!two_out || out_idx_ff[0]) begin
                  q_in = q_ff + DIV_BITS'(qs_ff) + DIV_BITS'(r_wrap);
                  r_in = r_adj[RATE_W-1:0];
               end
            end
         end
         S_EMIT: begin
            if (emit_done)
               state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_rate_ff   <= RATE_W'(44100);
         out_rate_ff  <= RATE_W'(44100);
         in_chan_ff   <= CHAN_W'(2);
         out_chan_ff  <= CHAN_W'(2);
         in_bytes_ff  <= BYTES_W'(2);
         out_bytes_ff <= BYTES_W'(2);
         pf_ff        <= PF_W'(1024);
         out_idx_ff   <= '0;
         in_idx_ff    <= '0;
         pkt_ff       <= '0;
         pos_valid_ff <= 1'b0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         in_rate_ff   <= in_rate_in;
         out_rate_ff  <= out_rate_in;
         in_chan_ff   <= in_chan_in;
         out_chan_ff  <= out_chan_in;
         in_bytes_ff  <= in_bytes_in;
         out_bytes_ff <= out_bytes_in;
         pf_ff        <= pf_in;
         out_idx_ff   <= out_idx_in;
         in_idx_ff    <= in_idx_in;
         pkt_ff       <= pkt_in;
         pos_valid_ff <= pos_valid_in;
         n_ff         <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff    <= q_in;
      r_ff    <= r_in;
      qs_ff   <= qs_in;
      rs_ff   <= rs_in;
      prod_ff <= prod_in;
      bits_ff <= bits_in;
   end

   pcmr_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   pcmr_rbuf u_rbuf (
      .clock           (clock),
      .reset           (reset),
      .wr              (wr),
      .emit            (emit),
      .emit_done       (emit_done),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_out_sample  (rsp_out_sample),
      .rsp_out_channel (rsp_out_channel),
      .rsp_packet_last (rsp_packet_last),
      .rsp_capped      (rsp_capped),
      .rsp_last        (rsp_last)
   );

`ifndef NO_ASSERTIONS
   a_n_range: assert property (@(posedge clock) disable iff (reset)
      n_ff <= RES_CNT_W'(MAX_RESULTS)) else $error("result count past cap");
   a_step_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_STEP |-> pos_valid_ff) else $error("stepping without position");
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_action) |=> state_ff != S_IDLE)
      else $error("sample request did not start work");
`endif

endmodule
